// ===== hdl/led_pkt_pkg.sv =====
// Shared types and constants for the LED packet responder.
// Depends on nothing; every other file in hdl/ except led_pkt_ram refers to it by scoped names.
`default_nettype none

package led_pkt_pkg;

   localparam int NUM_PACKETS = 8;
   localparam int DATA_BYTES  = 24;
   localparam int COL_DEPTH   = NUM_PACKETS * DATA_BYTES;
   localparam int VOLT_DEPTH  = DATA_BYTES;
   localparam int COL_AW      = (COL_DEPTH > 1) ? $clog2(COL_DEPTH) : 1;
   localparam int VOLT_AW     = (VOLT_DEPTH > 1) ? $clog2(VOLT_DEPTH) : 1;
   localparam int CNT_W       = $clog2(DATA_BYTES + 1);
   localparam int QDEPTH      = 2;
   localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W      = $clog2(QDEPTH + 1);

   localparam logic [7:0]       NUM_PACKETS_B = 8'(NUM_PACKETS);
   localparam logic [15:0]      COL_DEPTH_W   = 16'(COL_DEPTH);
   localparam logic [15:0]      VOLT_DEPTH_W  = 16'(VOLT_DEPTH);
   localparam logic [15:0]      DATA_BYTES_W  = 16'(DATA_BYTES);
   localparam logic [CNT_W-1:0] DATA_END      = CNT_W'(DATA_BYTES);
   localparam logic [CNT_W-1:0] DATA_LAST     = CNT_W'(DATA_BYTES - 1);

   // header characters
   localparam logic [7:0] HDR_EMERGENCY = 8'h45;
   localparam logic [7:0] HDR_RIGHT     = 8'h52;

   // request kinds, also used as queue entry opcodes
   localparam logic [1:0] REQ_LOAD_COL  = 2'd0;
   localparam logic [1:0] REQ_LOAD_VOLT = 2'd1;
   localparam logic [1:0] REQ_SHAKE     = 2'd2;

   // emergency flag action
   localparam logic [1:0] HDR_KEEP  = 2'd0;
   localparam logic [1:0] HDR_SET   = 2'd1;
   localparam logic [1:0] HDR_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [7:0]        byte_index;
      logic [7:0]        byte_value;
      logic [7:0]        header_byte;
      logic signed [7:0] requested_packet;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       end_of_packet;
      logic       emergency;
      logic       transfer_done;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]        op;
      logic [COL_AW-1:0] addr;
      logic [7:0]        value;
      logic [1:0]        hdr_act;
      logic [7:0]        num;
      logic              done;
      logic [COL_AW-1:0] base;
   } q_entry_type;

endpackage

`default_nettype wire

// ===== hdl/led_pkt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; read data holds while rd_en is low.
`default_nettype none

module led_pkt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                                         clock,
   input  wire logic                                         wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                         rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/led_pkt_front.sv =====
// Front end: accepts request words, drops useless ones, decodes the rest
// into queue entries. Uses led_pkt_pkg.
`default_nettype none

module led_pkt_front (
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire led_pkt_pkg::req_word_type req_word,
   output logic                           push_valid,
   input  wire logic                      push_ready,
   output led_pkt_pkg::q_entry_type       push_data
);

   logic [15:0] idx_w;
   logic [15:0] base_w;
   logic        col_ok;
   logic        volt_ok;
   logic        num_bad;
   logic [7:0]  num;
   logic        done;

   assign idx_w   = {8'd0, req_word.byte_index};
   assign col_ok  = idx_w < led_pkt_pkg::COL_DEPTH_W;
   assign volt_ok = idx_w < led_pkt_pkg::VOLT_DEPTH_W;

   // negative or too large packet numbers fall back to packet 0
   assign num_bad = req_word.requested_packet[7]
                 || (req_word.requested_packet[7:0] > led_pkt_pkg::NUM_PACKETS_B);
   assign num     = num_bad ? 8'd0 : req_word.requested_packet[7:0];
   assign done    = (num == led_pkt_pkg::NUM_PACKETS_B);
   assign base_w  = {8'd0, num} * led_pkt_pkg::DATA_BYTES_W;

   always_comb begin
      push_data.op    = req_word.req_type;
      push_data.addr  = idx_w[led_pkt_pkg::COL_AW-1:0];
      push_data.value = req_word.byte_value;
      push_data.num   = num;
      push_data.done  = done;
      push_data.base  = done ? '0 : base_w[led_pkt_pkg::COL_AW-1:0];

      priority if (req_word.header_byte == led_pkt_pkg::HDR_EMERGENCY) begin
         push_data.hdr_act = led_pkt_pkg::HDR_SET;
      end else if (req_word.header_byte == led_pkt_pkg::HDR_RIGHT) begin
         push_data.hdr_act = led_pkt_pkg::HDR_CLEAR;
      end else begin
         push_data.hdr_act = led_pkt_pkg::HDR_KEEP;
      end

      unique case (req_word.req_type)
         led_pkt_pkg::REQ_LOAD_COL:  push_valid = req_valid && col_ok;
         led_pkt_pkg::REQ_LOAD_VOLT: push_valid = req_valid && volt_ok;
         led_pkt_pkg::REQ_SHAKE:     push_valid = req_valid;
         default:                    push_valid = 1'b0;
      endcase
   end

   // dropped words are taken at the same pace as queued ones
   assign req_ready = push_ready;

endmodule

`default_nettype wire

// ===== hdl/led_pkt_queue.sv =====
// Small FIFO of decoded entries between front and back end.
// Uses led_pkt_pkg.
`default_nettype none

module led_pkt_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push_valid,
   output logic                          push_ready,
   input  wire led_pkt_pkg::q_entry_type push_data,
   output logic                          pop_valid,
   input  wire logic                     pop_ready,
   output led_pkt_pkg::q_entry_type      pop_data
);

   led_pkt_pkg::q_entry_type             ent_ff [led_pkt_pkg::QDEPTH];
   logic [led_pkt_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [led_pkt_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [led_pkt_pkg::QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                                 push;
   logic                                 pop;

   assign push_ready = (cnt_ff != led_pkt_pkg::QCNT_W'(led_pkt_pkg::QDEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = ent_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == led_pkt_pkg::QPTR_W'(led_pkt_pkg::QDEPTH - 1))
                   ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == led_pkt_pkg::QPTR_W'(led_pkt_pkg::QDEPTH - 1))
                   ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/led_pkt_back.sv =====
// Back end: executes store writes and streams reply packets.
// Uses led_pkt_pkg and two led_pkt_ram instances.
`default_nettype none

module led_pkt_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   output logic                          q_ready,
   input  wire led_pkt_pkg::q_entry_type q_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output led_pkt_pkg::rsp_word_type     rsp_word
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_NUM  = 2'd1;
   localparam logic [1:0] PH_DATA = 2'd2;
   localparam logic [1:0] PH_CSUM = 2'd3;

   logic [1:0]                          phase_ff, phase_in;
   logic [led_pkt_pkg::CNT_W-1:0]       rd_cnt_ff, rd_cnt_in;
   logic [led_pkt_pkg::CNT_W-1:0]       out_cnt_ff, out_cnt_in;
   logic [7:0]                          sum_ff, sum_in;
   logic [led_pkt_pkg::COL_AW-1:0]      base_ff, base_in;
   logic [7:0]                          num_ff, num_in;
   logic                                done_ff, done_in;
   logic                                emerg_ff, emerg_in;
   logic                                dvld_ff, dvld_in;
   logic                                rd_vld_ff, rd_vld_in;
   logic                                out_vld_ff, out_vld_in;
   led_pkt_pkg::rsp_word_type           out_ff, out_in;
   logic [led_pkt_pkg::COL_DEPTH-1:0]   col_vld_ff, col_vld_in;
   logic [led_pkt_pkg::VOLT_DEPTH-1:0]  volt_vld_ff, volt_vld_in;

   logic                                pop;
   logic                                out_free;
   logic                                take_data;
   logic                                rd_en;
   logic                                col_we;
   logic                                volt_we;
   logic [15:0]                         addr_w;
   logic [led_pkt_pkg::COL_AW-1:0]      col_rd_addr;
   logic [led_pkt_pkg::VOLT_AW-1:0]     volt_rd_addr;
   logic [led_pkt_pkg::VOLT_AW-1:0]     volt_wr_addr;
   logic [7:0]                          col_dout;
   logic [7:0]                          volt_dout;
   logic [7:0]                          rd_byte;

   assign q_ready   = (phase_ff == PH_IDLE);
   assign pop       = q_ready && q_valid;
   assign out_free  = !out_vld_ff || rsp_ready;
   assign take_data = (phase_ff == PH_DATA) && dvld_ff && out_free;
   assign rd_en     = ((phase_ff == PH_NUM) || (phase_ff == PH_DATA))
                   && (rd_cnt_ff != led_pkt_pkg::DATA_END)
                   && (!dvld_ff || take_data);
   assign col_we    = pop && (q_data.op == led_pkt_pkg::REQ_LOAD_COL);
   assign volt_we   = pop && (q_data.op == led_pkt_pkg::REQ_LOAD_VOLT);

   assign addr_w       = {{(16 - led_pkt_pkg::COL_AW){1'b0}}, base_ff}
                       + {{(16 - led_pkt_pkg::CNT_W){1'b0}}, rd_cnt_ff};
   assign col_rd_addr  = addr_w[led_pkt_pkg::COL_AW-1:0];
   assign volt_rd_addr = rd_cnt_ff[led_pkt_pkg::VOLT_AW-1:0];
   assign volt_wr_addr = q_data.addr[led_pkt_pkg::VOLT_AW-1:0];

   led_pkt_ram #(
      .WIDTH (8),
      .DEPTH (led_pkt_pkg::COL_DEPTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (col_we),
      .wr_addr (q_data.addr),
      .wr_data (q_data.value),
      .rd_en   (rd_en),
      .rd_addr (col_rd_addr),
      .rd_data (col_dout)
   );

   led_pkt_ram #(
      .WIDTH (8),
      .DEPTH (led_pkt_pkg::VOLT_DEPTH)
   ) u_volt_ram (
      .clock   (clock),
      .wr_en   (volt_we),
      .wr_addr (volt_wr_addr),
      .wr_data (q_data.value),
      .rd_en   (rd_en),
      .rd_addr (volt_rd_addr),
      .rd_data (volt_dout)
   );

   // entries never written since reset read as zero
   assign rd_byte = !rd_vld_ff ? 8'd0 : (done_ff ? volt_dout : col_dout);

   always_comb begin
      col_vld_in  = col_vld_ff;
      volt_vld_in = volt_vld_ff;
      if (col_we) begin
         col_vld_in[q_data.addr] = 1'b1;
      end
      if (volt_we) begin
         volt_vld_in[volt_wr_addr] = 1'b1;
      end

      rd_cnt_in = rd_cnt_ff;
      rd_vld_in = rd_vld_ff;
      if (rd_en) begin
         rd_cnt_in = rd_cnt_ff + 1'b1;
         rd_vld_in = done_ff ? volt_vld_ff[volt_rd_addr] : col_vld_ff[col_rd_addr];
      end
      dvld_in = (dvld_ff && !take_data) || rd_en;

      phase_in   = phase_ff;
      out_cnt_in = out_cnt_ff;
      sum_in     = sum_ff;
      base_in    = base_ff;
      num_in     = num_ff;
      done_in    = done_ff;
      emerg_in   = emerg_ff;
      out_vld_in = out_vld_ff && !rsp_ready;
      out_in     = out_ff;

      unique case (phase_ff)
         PH_IDLE: begin
            if (pop && (q_data.op == led_pkt_pkg::REQ_SHAKE)) begin
               phase_in   = PH_NUM;
               rd_cnt_in  = '0;
               out_cnt_in = '0;
               sum_in     = 8'd0;
               base_in    = q_data.base;
               num_in     = q_data.num;
               done_in    = q_data.done;
               priority if (q_data.hdr_act == led_pkt_pkg::HDR_SET) begin
                  emerg_in = 1'b1;
               end else if (q_data.hdr_act == led_pkt_pkg::HDR_CLEAR) begin
                  emerg_in = 1'b0;
               end else begin
                  emerg_in = emerg_ff;
               end
            end
         end
         PH_NUM: begin
            if (out_free) begin
               out_vld_in           = 1'b1;
               out_in.out_byte      = num_ff;
               out_in.end_of_packet = 1'b0;
               out_in.emergency     = emerg_ff;
               out_in.transfer_done = done_ff;
               phase_in             = PH_DATA;
            end
         end
         PH_DATA: begin
            if (take_data) begin
               out_vld_in           = 1'b1;
               out_in.out_byte      = rd_byte;
               out_in.end_of_packet = 1'b0;
               out_in.emergency     = emerg_ff;
               out_in.transfer_done = done_ff;
               sum_in               = sum_ff + rd_byte;
               if (out_cnt_ff == led_pkt_pkg::DATA_LAST) begin
                  phase_in = PH_CSUM;
               end else begin
                  out_cnt_in = out_cnt_ff + 1'b1;
               end
            end
         end
         PH_CSUM: begin
            if (out_free) begin
               out_vld_in           = 1'b1;
               out_in.out_byte      = 8'd0 - sum_ff;
               out_in.end_of_packet = 1'b1;
               out_in.emergency     = emerg_ff;
               out_in.transfer_done = done_ff;
               phase_in             = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         emerg_ff    <= 1'b0;
         dvld_ff     <= 1'b0;
         rd_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         col_vld_ff  <= '0;
         volt_vld_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         emerg_ff    <= emerg_in;
         dvld_ff     <= dvld_in;
         rd_vld_ff   <= rd_vld_in;
         out_vld_ff  <= out_vld_in;
         col_vld_ff  <= col_vld_in;
         volt_vld_ff <= volt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_cnt_ff  <= rd_cnt_in;
      out_cnt_ff <= out_cnt_in;
      sum_ff     <= sum_in;
      base_ff    <= base_in;
      num_ff     <= num_in;
      done_ff    <= done_in;
      out_ff     <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;

endmodule

`default_nettype wire

// ===== hdl/led_packet_responder.sv =====
// LED packet responder, top level.
// Instantiates led_pkt_front, led_pkt_queue and led_pkt_back; uses led_pkt_pkg.
//
// Usage:
//   req_* channel (valid/ready) takes one request word: a colour byte load,
//   a voltage byte load, or a handshake carrying the partner header and the
//   requested packet number. Loads with an index past their store, and
//   request kind 3, are taken and dropped.
//   rsp_* channel (valid/ready) returns the reply to each handshake as
//   DATA_BYTES+2 words: packet number, data bytes, checksum (end_of_packet
//   set on the checksum word). Loads produce no words.
//   A two-entry queue sits between the decoder and the executor, so requests
//   keep being taken while the executor works or the receiver stalls.
//   A load is executed as the executor takes it from the queue. A handshake
//   is taken from the queue, then streams one word per cycle while the
//   receiver is ready, paced by the single read port of the store RAMs. With
//   an idle block, an accepted handshake passes the queue register and the
//   executor phase register, then the output register holds the first word.
//   A stalled receiver holds the output register and backs up the RAM read stage, then the queue, then req_ready.
//   Reset clears the emergency flag and marks every store byte as zero
//   (per-byte valid bits, no clearing pass); it is usable the next cycle.
`default_nettype none

module led_packet_responder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire led_pkt_pkg::req_word_type req_word,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output led_pkt_pkg::rsp_word_type      rsp_word
);

   logic                     push_valid;
   logic                     push_ready;
   led_pkt_pkg::q_entry_type push_data;
   logic                     q_valid;
   logic                     q_ready;
   led_pkt_pkg::q_entry_type q_data;

   led_pkt_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   led_pkt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   led_pkt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_data    (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   // two checksum words never follow back to back
   a_eop_gap: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_ready && rsp_word.end_of_packet)
       && rsp_valid) |-> !rsp_word.end_of_packet)
      else $error("two checksum words in a row");

   // packet kind stays fixed across a packet
   a_done_steady: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_ready && !rsp_word.end_of_packet)
       && rsp_valid) |-> (rsp_word.transfer_done == $past(rsp_word.transfer_done)))
      else $error("transfer_done changed inside a packet");

   // emergency flag only moves between packets
   a_emerg_steady: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(rsp_valid && rsp_ready && !rsp_word.end_of_packet)
       && rsp_valid) |-> (rsp_word.emergency == $past(rsp_word.emergency)))
      else $error("emergency changed inside a packet");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for led_packet_responder: sends colour/voltage load words and handshakes,
// mirrors both byte stores and the emergency flag, and checks each reply word in order.
// Depends on hdl/led_pkt_pkg.sv and hdl/led_packet_responder.sv.

module testbench;

   localparam logic [1:0] REQ_UNUSED   = 2'd3;
   localparam int         DRAIN_CYCLES = 40;
   localparam int         RANDOM_ITEMS = 50;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   led_pkt_pkg::req_word_type req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   led_pkt_pkg::rsp_word_type rsp_word;

   logic [7:0]                colour_mirror [led_pkt_pkg::COL_DEPTH];
   logic [7:0]                volt_mirror [led_pkt_pkg::VOLT_DEPTH];
   logic                      emerg_mirror;
   led_pkt_pkg::rsp_word_type reply_queue [$];
   led_pkt_pkg::rsp_word_type want;
   int                        mismatch_count = 0;
   bit                        steady = 1'b0;    // set: neither side idles

   led_packet_responder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #4_000_000;
      $display("FAILURE");
      $finish;
   end

   function automatic bit roll_idle();
      return !steady && ($urandom_range(99) < 24);
   endfunction

   always @(posedge clock) begin
      rsp_ready <= !roll_idle();
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Reply words are checked against the oldest expectation, field by field.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (reply_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", rsp_word));
         end else begin
            want = reply_queue.pop_front();
            if (rsp_word.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %h, want %h",
                                         rsp_word.out_byte, want.out_byte));
            if (rsp_word.end_of_packet !== want.end_of_packet)
               report_mismatch($sformatf("end_of_packet %b, want %b",
                                         rsp_word.end_of_packet, want.end_of_packet));
            if (rsp_word.emergency !== want.emergency)
               report_mismatch($sformatf("emergency %b, want %b",
                                         rsp_word.emergency, want.emergency));
            if (rsp_word.transfer_done !== want.transfer_done)
               report_mismatch($sformatf("transfer_done %b, want %b",
                                         rsp_word.transfer_done, want.transfer_done));
         end
      end
   end

   // Updates the store mirrors and queues the packet a handshake produces.
   task automatic predict_reply(input led_pkt_pkg::req_word_type w);
      logic [7:0]                pkt;
      logic [7:0]                b;
      logic [7:0]                sum;
      logic                      volt_pkt;
      led_pkt_pkg::rsp_word_type r;
      int                        i;
      case (w.req_type)
         led_pkt_pkg::REQ_LOAD_COL: begin
            if (w.byte_index < led_pkt_pkg::COL_DEPTH)
               colour_mirror[w.byte_index] = w.byte_value;
         end
         led_pkt_pkg::REQ_LOAD_VOLT: begin
            if (w.byte_index < led_pkt_pkg::VOLT_DEPTH)
               volt_mirror[w.byte_index] = w.byte_value;
         end
         led_pkt_pkg::REQ_SHAKE: begin
            if (w.header_byte == led_pkt_pkg::HDR_EMERGENCY) emerg_mirror = 1'b1;
            else if (w.header_byte == led_pkt_pkg::HDR_RIGHT) emerg_mirror = 1'b0;
            pkt = w.requested_packet;
            if (pkt[7] || pkt > led_pkt_pkg::NUM_PACKETS_B) pkt = 8'd0;
            volt_pkt = (pkt == led_pkt_pkg::NUM_PACKETS_B);
            sum = 8'd0;
            r.out_byte = pkt;
            r.end_of_packet = 1'b0;
            r.emergency = emerg_mirror;
            r.transfer_done = volt_pkt;
            reply_queue.push_back(r);
            for (i = 0; i < led_pkt_pkg::DATA_BYTES; i++) begin
               b = volt_pkt ? volt_mirror[i]
                            : colour_mirror[pkt * led_pkt_pkg::DATA_BYTES + i];
               sum = sum + b;
               r.out_byte = b;
               reply_queue.push_back(r);
            end
            r.out_byte = -sum;
            r.end_of_packet = 1'b1;
            reply_queue.push_back(r);
         end
         default: ;
      endcase
   endtask

   // Valid stays high across back-to-back words; it drops only for a gap.
   task automatic send_word(input led_pkt_pkg::req_word_type w);
      if (roll_idle()) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (roll_idle());
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (!req_ready);
      predict_reply(w);
   endtask

   task automatic wait_for_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (reply_queue.size() != 0) @(posedge clock);
   endtask

   function automatic led_pkt_pkg::req_word_type load_word(input logic [1:0] kind,
                                                           input logic [7:0] idx,
                                                           input logic [7:0] val);
      led_pkt_pkg::req_word_type w;
      w.req_type = kind;
      w.byte_index = idx;
      w.byte_value = val;
      w.header_byte = 8'($urandom);
      w.requested_packet = 8'($urandom);
      return w;
   endfunction

   function automatic led_pkt_pkg::req_word_type shake_word(input logic [7:0] hdr,
                                                            input logic [7:0] pkt);
      led_pkt_pkg::req_word_type w;
      w.req_type = led_pkt_pkg::REQ_SHAKE;
      w.byte_index = 8'($urandom);
      w.byte_value = 8'($urandom);
      w.header_byte = hdr;
      w.requested_packet = pkt;
      return w;
   endfunction

   function automatic logic [7:0] pick_header();
      int r;
      r = $urandom_range(99);
      if (r < 30) return led_pkt_pkg::HDR_EMERGENCY;
      if (r < 60) return led_pkt_pkg::HDR_RIGHT;
      return 8'($urandom);
   endfunction

   task automatic test_reset_contents();
      send_word(shake_word(8'h00, 8'd0));
      send_word(shake_word(8'h00, led_pkt_pkg::NUM_PACKETS_B));
   endtask

   task automatic test_load_edges();
      led_pkt_pkg::req_word_type w;
      send_word(load_word(led_pkt_pkg::REQ_LOAD_COL, 8'd0, 8'hFF));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_COL, 8'(led_pkt_pkg::COL_DEPTH - 1), 8'hA5));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_COL, 8'(led_pkt_pkg::COL_DEPTH), 8'h5A));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_COL, 8'hFF, 8'h01));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_VOLT, 8'd0, 8'h80));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_VOLT, 8'(led_pkt_pkg::VOLT_DEPTH - 1),
                          8'hFF));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_VOLT, 8'(led_pkt_pkg::VOLT_DEPTH), 8'h33));
      send_word(load_word(led_pkt_pkg::REQ_LOAD_VOLT, 8'hFF, 8'h44));
      // unused kind must neither write colour byte 0 nor touch the flag
      w = load_word(REQ_UNUSED, 8'd0, 8'h77);
      w.header_byte = led_pkt_pkg::HDR_EMERGENCY;
      send_word(w);
      send_word(shake_word(8'h00, 8'd0));
      send_word(shake_word(8'h00, led_pkt_pkg::NUM_PACKETS_B - 8'd1));
      send_word(shake_word(8'h00, led_pkt_pkg::NUM_PACKETS_B));
   endtask

   task automatic test_header_cases();
      send_word(shake_word(led_pkt_pkg::HDR_EMERGENCY, 8'h80));
      send_word(shake_word(8'h00, 8'd1));
      send_word(shake_word(led_pkt_pkg::HDR_RIGHT, 8'h7F));
      send_word(shake_word(8'hFF, led_pkt_pkg::NUM_PACKETS_B));
      send_word(shake_word(led_pkt_pkg::HDR_EMERGENCY, 8'hFF));
      send_word(shake_word(led_pkt_pkg::HDR_RIGHT, led_pkt_pkg::NUM_PACKETS_B + 8'd1));
   endtask

   // Mostly: fill part of one packet, then ask for it. Rest is noise.
   task automatic test_packet_traffic();
      int                        counted;
      int                        r;
      int                        pkt_sel;
      int                        nload;
      int                        off;
      led_pkt_pkg::req_word_type w;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         r = $urandom_range(99);
         if (r < 60) begin
            pkt_sel = $urandom_range(led_pkt_pkg::NUM_PACKETS);
            nload = $urandom_range(led_pkt_pkg::DATA_BYTES, 1);
            repeat (nload) begin
               off = $urandom_range(led_pkt_pkg::DATA_BYTES - 1);
               if (pkt_sel == led_pkt_pkg::NUM_PACKETS)
                  send_word(load_word(led_pkt_pkg::REQ_LOAD_VOLT, 8'(off), 8'($urandom)));
               else
                  send_word(load_word(led_pkt_pkg::REQ_LOAD_COL,
                                      8'(pkt_sel * led_pkt_pkg::DATA_BYTES + off),
                                      8'($urandom)));
            end
            send_word(shake_word(pick_header(), 8'(pkt_sel)));
            counted += nload + 1;
         end else if (r < 80) begin
            send_word(shake_word(pick_header(), 8'($urandom)));
            counted++;
         end else if (r < 95) begin
            w = load_word($urandom_range(1) ? led_pkt_pkg::REQ_LOAD_VOLT
                                            : led_pkt_pkg::REQ_LOAD_COL,
                          8'($urandom), 8'($urandom));
            send_word(w);
            if ((w.req_type == led_pkt_pkg::REQ_LOAD_COL &&
                 w.byte_index < led_pkt_pkg::COL_DEPTH) ||
                (w.req_type == led_pkt_pkg::REQ_LOAD_VOLT &&
                 w.byte_index < led_pkt_pkg::VOLT_DEPTH))
               counted++;
         end else begin
            send_word(load_word(REQ_UNUSED, 8'($urandom), 8'($urandom)));
         end
      end
   endtask

   // Drain fully, then one full packet fill and handshakes with no idling.
   task automatic test_drain_then_burst();
      int pkt_sel;
      int off;
      wait_for_replies();
      steady = 1'b1;
      pkt_sel = $urandom_range(led_pkt_pkg::NUM_PACKETS - 1);
      for (off = 0; off < led_pkt_pkg::DATA_BYTES; off++)
         send_word(load_word(led_pkt_pkg::REQ_LOAD_COL,
                             8'(pkt_sel * led_pkt_pkg::DATA_BYTES + off), 8'($urandom)));
      send_word(shake_word(pick_header(), 8'(pkt_sel)));
      send_word(shake_word(pick_header(), led_pkt_pkg::NUM_PACKETS_B));
      send_word(shake_word(pick_header(), 8'($urandom)));
      wait_for_replies();
      steady = 1'b0;
   endtask

   initial begin
      foreach (colour_mirror[i]) colour_mirror[i] = 8'd0;
      foreach (volt_mirror[i]) volt_mirror[i] = 8'd0;
      emerg_mirror = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_contents();
      test_load_edges();
      test_header_cases();
      test_packet_traffic();
      test_drain_then_burst();
      test_packet_traffic();
      wait_for_replies();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/led_pkt_pkg.sv
hdl/led_pkt_ram.sv
hdl/led_pkt_front.sv
hdl/led_pkt_queue.sv
hdl/led_pkt_back.sv
hdl/led_packet_responder.sv
test/testbench.sv
